FILE: design/rme_pkg.sv
package rme_pkg;

   // Width of the request, response and register fields
   localparam int FIELD_W = 32;
   localparam int CSR_INDEX_W = 2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MODULUS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PUBLIC_EXP = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRIVATE_EXP = 2'd2;

   // Action codes
   localparam logic ACTION_ENCRYPT = 1'b0;
   localparam logic ACTION_DECRYPT = 1'b1;

   // Control that travels with each request through the stages
   typedef struct packed {
      logic valid;
      logic action;
   } stage_ctl_type;

endpackage

FILE: design/rme_req_if.sv
interface rme_req_if import rme_pkg::*; ();
   logic valid;
   logic ready;
   logic action;
   logic [FIELD_W-1:0] message;

   modport source (output valid, output action, output message, input ready);
   modport sink (input valid, input action, input message, output ready);
endinterface

FILE: design/rme_rsp_if.sv
interface rme_rsp_if import rme_pkg::*; ();
   logic valid;
   logic ready;
   logic [FIELD_W-1:0] result_value;

   modport source (output valid, output result_value, input ready);
   modport sink (input valid, input result_value, output ready);
endinterface

FILE: design/rme_div_stage.sv
module rme_div_stage import rme_pkg::*; #(
   parameter int W = 32,
   parameter int BIT_IDX = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  stage_ctl_type ctl_in,
   input  logic [W-1:0]  modulus,
   input  logic [W-1:0]  rem_in,
   input  logic [W-1:0]  msg_in,
   output stage_ctl_type ctl_out,
   output logic [W-1:0]  rem_out,
   output logic [W-1:0]  msg_out
);

   stage_ctl_type ctl_ff;
   logic [W-1:0] rem_ff, rem_in_next;
   logic [W-1:0] msg_ff;
   logic [W:0] shifted, diff;

   // Bring down one message bit and subtract the modulus if it fits
   always_comb begin
      shifted = {rem_in, msg_in[BIT_IDX]};
      diff = shifted - {1'b0, modulus};
      rem_in_next = (shifted >= {1'b0, modulus}) ? diff[W-1:0] : shifted[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in_next;
         msg_ff <= msg_in;
      end
   end

   assign ctl_out = ctl_ff;
   assign rem_out = rem_ff;
   assign msg_out = msg_ff;

endmodule

FILE: design/rme_mul_stage.sv
module rme_mul_stage import rme_pkg::*; #(
   parameter int W = 32,
   parameter int BIT_IDX = 0,
   parameter bit FINAL = 1'b0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  stage_ctl_type ctl_in,
   input  logic          exp_bit,
   input  logic [W-1:0]  modulus,
   input  logic [W-1:0]  r_in,
   input  logic [W-1:0]  base_in,
   input  logic [W-1:0]  acc1_in,
   input  logic [W-1:0]  acc2_in,
   output stage_ctl_type ctl_out,
   output logic [W-1:0]  r_out,
   output logic [W-1:0]  base_out,
   output logic [W-1:0]  acc1_out,
   output logic [W-1:0]  acc2_out
);

   stage_ctl_type ctl_ff;
   logic [W-1:0] r_ff, base_ff, acc1_ff, acc2_ff;
   logic [W-1:0] r_in_next, base_in_next, acc1_in_next, acc2_in_next;
   logic [W-1:0] step1, step2;
   logic mul_bit;

   // One shift-and-add step: (2*acc + add) mod n, the sum stays below 3n
   function automatic logic [W-1:0] dbl_add(input logic [W-1:0] acc,
                                            input logic [W-1:0] add,
                                            input logic [W-1:0] n);
      logic [W+1:0] sum, d1, d2;
      logic [W-1:0] res;
      sum = {1'b0, acc, 1'b0} + {2'b00, add};
      d1 = sum - {2'b00, n};
      d2 = sum - {1'b0, n, 1'b0};
      if (sum >= {1'b0, n, 1'b0}) begin
         res = d2[W-1:0];
      end else if (sum >= {2'b00, n}) begin
         res = d1[W-1:0];
      end else begin
         res = sum[W-1:0];
      end
      return res;
   endfunction

   // Multiply result by base and base by base, one bit of base per stage
   always_comb begin
      mul_bit = base_in[BIT_IDX];
      step1 = dbl_add(acc1_in, mul_bit ? r_in : '0, modulus);
      step2 = dbl_add(acc2_in, mul_bit ? base_in : '0, modulus);
      if (FINAL) begin
         r_in_next = exp_bit ? step1 : r_in;
         base_in_next = step2;
         acc1_in_next = '0;
         acc2_in_next = '0;
      end else begin
         r_in_next = r_in;
         base_in_next = base_in;
         acc1_in_next = step1;
         acc2_in_next = step2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r_ff <= r_in_next;
         base_ff <= base_in_next;
         acc1_ff <= acc1_in_next;
         acc2_ff <= acc2_in_next;
      end
   end

   assign ctl_out = ctl_ff;
   assign r_out = r_ff;
   assign base_out = base_ff;
   assign acc1_out = acc1_ff;
   assign acc2_out = acc2_ff;

endmodule

FILE: design/rsa_modular_exponentiation_core.sv
// The pipeline has one stage per message bit for the input reduction, then one
// stage per base bit for each exponent bit's square and multiply.
// Throughput: one request per cycle; a stalled response holds the whole pipeline.
// Reset: synchronous, active high; clears all stage valid bits and sets
// modulus to 2 and both exponents to 1.
module rsa_modular_exponentiation_core import rme_pkg::*; #(
   parameter int MODULUS_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   rme_req_if.sink                req_ch,
   rme_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [FIELD_W-1:0]     csr_wdata
);

   localparam int W = MODULUS_WIDTH;
   localparam int NMUL = W * W;

   logic [W-1:0] modulus_ff, pub_exp_ff, priv_exp_ff;
   logic advance;

   stage_ctl_type div_ctl [0:W];
   logic [W-1:0] div_rem [0:W];
   logic [W-1:0] div_msg [0:W];

   stage_ctl_type mul_ctl [0:NMUL];
   logic [W-1:0] mul_r [0:NMUL];
   logic [W-1:0] mul_base [0:NMUL];
   logic [W-1:0] mul_acc1 [0:NMUL];
   logic [W-1:0] mul_acc2 [0:NMUL];

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= W'(2);
         pub_exp_ff <= W'(1);
         priv_exp_ff <= W'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODULUS: modulus_ff <= W'(csr_wdata);
            CSR_PUBLIC_EXP: pub_exp_ff <= W'(csr_wdata);
            CSR_PRIVATE_EXP: priv_exp_ff <= W'(csr_wdata);
            default: ;
         endcase
      end
   end

   // Advance the pipeline unless a response is waiting
   assign advance = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = advance;

   // Reduce the message modulo the modulus
   assign div_ctl[0] = '{valid: req_ch.valid, action: req_ch.action};
   assign div_rem[0] = '0;
   assign div_msg[0] = W'(req_ch.message);

   for (genvar j = 0; j < W; j++) begin : g_div
      rme_div_stage #(.W(W), .BIT_IDX(W - 1 - j)) u_div (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .ctl_in  (div_ctl[j]),
         .modulus (modulus_ff),
         .rem_in  (div_rem[j]),
         .msg_in  (div_msg[j]),
         .ctl_out (div_ctl[j+1]),
         .rem_out (div_rem[j+1]),
         .msg_out (div_msg[j+1])
      );
   end

   // Seed square-and-multiply with result = 1 mod n
   assign mul_ctl[0] = div_ctl[W];
   assign mul_r[0] = (modulus_ff >= W'(2)) ? W'(1) : '0;
   assign mul_base[0] = div_rem[W];
   assign mul_acc1[0] = '0;
   assign mul_acc2[0] = '0;

   // Exponent bits from LSB, one group of W stages per bit
   for (genvar s = 0; s < NMUL; s++) begin : g_mul
      logic exp_bit;
      assign exp_bit = (mul_ctl[s].action == ACTION_DECRYPT) ? priv_exp_ff[s / W]
                                                              : pub_exp_ff[s / W];
      rme_mul_stage #(
         .W       (W),
         .BIT_IDX (W - 1 - (s % W)),
         .FINAL   ((s % W) == (W - 1))
      ) u_mul (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .ctl_in   (mul_ctl[s]),
         .exp_bit  (exp_bit),
         .modulus  (modulus_ff),
         .r_in     (mul_r[s]),
         .base_in  (mul_base[s]),
         .acc1_in  (mul_acc1[s]),
         .acc2_in  (mul_acc2[s]),
         .ctl_out  (mul_ctl[s+1]),
         .r_out    (mul_r[s+1]),
         .base_out (mul_base[s+1]),
         .acc1_out (mul_acc1[s+1]),
         .acc2_out (mul_acc2[s+1])
      );
   end

   // Drive the response from the last stage; modulus zero gives zero
   assign rsp_ch.valid = mul_ctl[NMUL].valid;
   assign rsp_ch.result_value = (modulus_ff == '0) ? '0 : FIELD_W'(mul_r[NMUL]);

`ifndef SYNTHESIS
   a_result_below_modulus: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (modulus_ff != '0) |-> (mul_r[NMUL] < modulus_ff))
      else $error("result not reduced below modulus");

   a_no_response_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("response valid right after reset");

   a_stall_holds_entry: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(div_ctl[1]))
      else $error("first stage moved during stall");
`endif

endmodule

FILE: verif/tb_rsa_modular_exponentiation_core.sv
`timescale 1ns / 100ps

module tb_rsa_modular_exponentiation_core;
   import rme_pkg::*;

   localparam int LATENCY = 32 * 33;
   localparam int N_RANDOM = 1930;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [FIELD_W-1:0] csr_wdata;
   int error_count;

   rme_req_if req_ch ();
   rme_rsp_if rsp_ch ();

   rsa_modular_exponentiation_core #(.MODULUS_WIDTH(32)) dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Key material as the block sees it
   logic [31:0] key_modulus;
   logic [31:0] key_public;
   logic [31:0] key_private;

   // (a + b) mod m for a, b below m
   function automatic logic [31:0] add_residue(logic [31:0] a, logic [31:0] b,
                                               logic [31:0] m);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, m}) s = s - {1'b0, m};
      return s[31:0];
   endfunction

   // Square-and-multiply with exact 64-bit products
   function automatic logic [31:0] power_residue(logic [31:0] base, logic [31:0] ex,
                                                 logic [31:0] m);
      logic [63:0] acc;
      logic [63:0] b;
      if (m == 0) return '0;
      acc = 64'd1 % m;
      b = base % m;
      for (int i = 0; i < 32; i++) begin
         if (ex[i]) acc = (acc * b) % m;
         b = (b * b) % m;
      end
      return acc[31:0];
   endfunction

   // Hold expected result values in request order
   class cipher_scoreboard;
      logic [31:0] pending_results[$];

      function void note_request(logic act, logic [31:0] msg, logic [31:0] m,
                                 logic [31:0] pe, logic [31:0] de);
         pending_results.push_back(power_residue(msg, act ? de : pe, m));
      endfunction

      function bit check_result(logic [31:0] got, output logic [31:0] want);
         if (pending_results.size() == 0) begin
            want = 'x;
            return 0;
         end
         want = pending_results.pop_front();
         return got === want;
      endfunction
   endclass

   cipher_scoreboard board;

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Clock generation
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Mostly short gaps, occasionally long
   function automatic int gap_length();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
      return $urandom_range(0, 3);
   endfunction

   bit idle_phase;

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_MODULUS) key_modulus = val;
      else if (idx == CSR_PUBLIC_EXP) key_public = val;
      else if (idx == CSR_PRIVATE_EXP) key_private = val;
   endtask

   task automatic load_key(logic [31:0] m, logic [31:0] pe, logic [31:0] de);
      write_register(CSR_MODULUS, m);
      write_register(CSR_PUBLIC_EXP, pe);
      write_register(CSR_PRIVATE_EXP, de);
      // Unused index must be ignored
      write_register(2'd3, $urandom);
   endtask

   // Wait for the pipeline to drain
   task automatic wait_drained();
      while (board.pending_results.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Drive one request; valid stays high across back-to-back requests
   task automatic send_request(logic act, logic [31:0] msg);
      int g;
      g = idle_phase ? 0 : gap_length();
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.action <= act;
      req_ch.message <= msg;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_request(act, msg, key_modulus, key_public, key_private);
      @(negedge clock);
   endtask

   task automatic end_burst();
      req_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [31:0] random_message();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return key_modulus - 1;
         3: return key_modulus;
         default: return $urandom;
      endcase
   endfunction

   // Sink side: random backpressure, check at the rising edge
   initial begin
      logic [31:0] want;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         rsp_ch.ready <= (idle_phase || gap_length() == 0) ? 1'b1 : 1'b0;
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (!board.check_result(rsp_ch.result_value, want))
               report_mismatch("result_value", rsp_ch.result_value, want);
         end
         @(negedge clock);
      end
   end

   // Stimulus
   initial begin
      logic [31:0] mods[6];
      board = new();
      error_count = 0;
      idle_phase = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.action = ACTION_ENCRYPT;
      req_ch.message = '0;
      key_modulus = 2;
      key_public = 1;
      key_private = 1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset key values
      send_request(ACTION_ENCRYPT, '1);
      send_request(ACTION_DECRYPT, 32'd3);
      end_burst();
      wait_drained();

      // Textbook key: n = 3233, e = 17, d = 2753
      load_key(32'd3233, 32'd17, 32'd2753);
      send_request(ACTION_ENCRYPT, 32'd65);
      send_request(ACTION_DECRYPT, 32'd2790);
      send_request(ACTION_ENCRYPT, 32'd0);
      send_request(ACTION_ENCRYPT, 32'd3233);
      send_request(ACTION_DECRYPT, '1);
      end_burst();
      wait_drained();

      // Modulus zero and one, exponent zero
      load_key(32'd0, 32'd5, 32'd7);
      send_request(ACTION_ENCRYPT, 32'd9);
      send_request(ACTION_DECRYPT, '1);
      end_burst();
      wait_drained();
      load_key(32'd1, 32'd0, '1);
      send_request(ACTION_ENCRYPT, 32'd9);
      send_request(ACTION_DECRYPT, 32'd0);
      end_burst();
      wait_drained();
      load_key('1, 32'd0, '1);
      send_request(ACTION_ENCRYPT, 32'd0);
      send_request(ACTION_DECRYPT, 32'hFFFF_FFFE);
      send_request(ACTION_DECRYPT, '1);
      send_request(ACTION_ENCRYPT, 32'h8000_0001);
      end_burst();
      wait_drained();

      // Random phases with varied keys; the last phase runs without idling
      mods = '{32'd2, 32'hFFFF_FFFB, 32'h8000_0000, 32'd3233, 32'd1, 32'd0};
      for (int ph = 0; ph < 10; ph++) begin
         load_key(ph < 6 ? mods[ph] : $urandom, $urandom, ph == 7 ? '1 : $urandom);
         idle_phase = (ph == 9);
         for (int i = 0; i < N_RANDOM / 10; i++)
            send_request($urandom_range(0, 1), random_message());
         end_burst();
         wait_drained();
      end
      idle_phase = 0;

      repeat (LATENCY + 50) @(negedge clock);
      if (error_count == 0 && board.pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Timeout
   initial begin
      #(64'd8 * 64'd2_000_000);
      $display("Regression FAIL");
      $finish;
   end

endmodule
